@@ sv/pjt_pkg.sv @@
package pjt_pkg;

  // Table size and field widths
  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int CMD_W         = 3;
  localparam int SLOT_W        = 3;
  localparam int KIND_W        = 3;
  localparam int LIMIT_W       = 8;
  localparam int IVL_W         = 16;
  localparam int NREP_W        = $clog2(MAX_RESULTS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD          = 3'd0,
    CMD_START        = 3'd1,
    CMD_STOP         = 3'd2,
    CMD_REMOVE       = 3'd3,
    CMD_SET_INTERVAL = 3'd4,
    CMD_TICK         = 3'd5,
    CMD_QUERY        = 3'd6
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED     = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_ACK       = 3'd2,
    KIND_FIRED     = 3'd3,
    KIND_IDLE_TICK = 3'd4,
    KIND_STATUS    = 3'd5
  } kind_t;

  // Operation broadcast to every slot cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_START,
    OP_STOP,
    OP_REMOVE,
    OP_SETIV,
    OP_TICK
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_TICK,
    ST_FLUSH
  } state_t;

  // Controller to cells
  typedef struct packed {
    cell_op_t           op;
    logic               step;      // shift the scan token one cell
    logic               inject;    // token enters cell 0 on a step
    logic               tok_clr;   // drop the token
    logic [SLOT_W-1:0]  job_id;
    logic [LIMIT_W-1:0] repeat_limit;
    logic [IVL_W-1:0]   interval;
    logic               start_now;
    logic               free_when_done;
  } cell_ctl_t;

  // Cells to controller; each cell drives zeros unless it holds the token
  // (or is addressed, for qrun), so the row is combined by OR
  typedef struct packed {
    logic               free;
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [LIMIT_W-1:0] fire_count;
    logic               run_after;
    logic               qrun;
  } cell_stat_t;

endpackage

@@ sv/pjt_cell.sv @@
module pjt_cell #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pjt_pkg::cell_ctl_t   ctl,
  input  logic                 tok_in,
  output logic                 tok_out,
  output pjt_pkg::cell_stat_t  stat
);
  import pjt_pkg::*;

  logic               tok_r, tok_nxt;
  logic               in_use_r, in_use_nxt;
  logic               active_r, active_nxt;
  logic               fwd_r, fwd_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [LIMIT_W-1:0] fc_r, fc_nxt;
  logic [IVL_W-1:0]   ivl_r, ivl_nxt;
  logic [IVL_W-1:0]   tick_r, tick_nxt;

  logic               sel;
  logic               running;
  logic               hit;
  logic               done;
  logic [IVL_W-1:0]   cnt1;
  logic [LIMIT_W-1:0] fc1;

  // Slot decode and tick arithmetic
  assign sel     = (int'(ctl.job_id) == IDX);
  assign running = in_use_r & active_r;
  assign cnt1    = tick_r + IVL_W'(1);
  assign hit     = running && (cnt1 == ivl_r);
  assign fc1     = fc_r + LIMIT_W'(1);
  assign done    = (limit_r != '0) && (fc1 == limit_r);

  // Scan token moves to the neighbor on each step
  always_comb begin
    if (ctl.tok_clr) begin
      tok_nxt = 1'b0;
    end else if (ctl.step) begin
      tok_nxt = tok_in;
    end else begin
      tok_nxt = tok_r;
    end
  end

  // Slot state update
  always_comb begin
    in_use_nxt = in_use_r;
    active_nxt = active_r;
    fwd_nxt    = fwd_r;
    limit_nxt  = limit_r;
    fc_nxt     = fc_r;
    ivl_nxt    = ivl_r;
    tick_nxt   = tick_r;
    case (ctl.op)
      OP_ADD: begin
        if (tok_r) begin
          in_use_nxt = 1'b1;
          active_nxt = ctl.start_now;
          fwd_nxt    = ctl.free_when_done;
          limit_nxt  = ctl.repeat_limit;
          fc_nxt     = '0;
          ivl_nxt    = ctl.interval;
          tick_nxt   = '0;
        end
      end
      OP_START: begin
        if (sel) active_nxt = 1'b1;
      end
      OP_STOP: begin
        if (sel) active_nxt = 1'b0;
      end
      OP_REMOVE: begin
        if (sel) in_use_nxt = 1'b0;
      end
      OP_SETIV: begin
        if (sel) ivl_nxt = ctl.interval;
      end
      OP_TICK: begin
        if (tok_r && running) begin
          if (hit) begin
            tick_nxt = '0;
            fc_nxt   = fc1;
            if (done) begin
              if (fwd_r) in_use_nxt = 1'b0;
              else       active_nxt = 1'b0;
            end
          end else begin
            tick_nxt = cnt1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r    <= 1'b0;
      in_use_r <= 1'b0;
      active_r <= 1'b0;
    end else begin
      tok_r    <= tok_nxt;
      in_use_r <= in_use_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r   <= fwd_nxt;
    limit_r <= limit_nxt;
    fc_r    <= fc_nxt;
    ivl_r   <= ivl_nxt;
    tick_r  <= tick_nxt;
  end

  // Status, zero unless this cell holds the token or is addressed
  assign tok_out = tok_r;
  always_comb begin
    stat            = '0;
    stat.free       = tok_r & ~in_use_r;
    stat.hit        = tok_r & hit;
    stat.slot       = tok_r ? SLOT_W'(IDX) : '0;
    stat.fire_count = (tok_r & hit) ? fc1 : '0;
    stat.run_after  = tok_r & hit & ~done;
    stat.qrun       = sel & running;
  end

endmodule

@@ sv/pjt_ctrl.sv @@
module pjt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pjt_pkg::CMD_W-1:0]     in_command,
  input  logic [pjt_pkg::SLOT_W-1:0]    in_job_id,
  input  logic [pjt_pkg::LIMIT_W-1:0]   in_repeat_limit,
  input  logic [pjt_pkg::IVL_W-1:0]     in_interval_ticks,
  input  logic                          in_start_now,
  input  logic                          in_free_when_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pjt_pkg::KIND_W-1:0]    out_kind,
  output logic [pjt_pkg::SLOT_W-1:0]    out_slot,
  output logic [pjt_pkg::LIMIT_W-1:0]   out_fire_count,
  output logic                          out_running,
  output logic                          out_last,
  input  pjt_pkg::cell_stat_t           stat,
  input  logic                          tok_last,
  output pjt_pkg::cell_ctl_t            ctl
);
  import pjt_pkg::*;

  state_t             state_r, state_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic [LIMIT_W-1:0] out_fc_r, out_fc_nxt;
  logic               out_run_r, out_run_nxt;
  logic               out_last_r, out_last_nxt;

  // One fire result held back until it is known whether it is the last
  logic               pend_valid_r, pend_valid_nxt;
  logic [SLOT_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic [LIMIT_W-1:0] pend_fc_r, pend_fc_nxt;
  logic               pend_run_r, pend_run_nxt;
  logic [NREP_W-1:0]  nrep_r, nrep_nxt;

  // Add parameters held while the token searches
  logic [LIMIT_W-1:0] lim_r;
  logic [IVL_W-1:0]   ivl_r;
  logic               start_r;
  logic               fwd_r;

  cmd_t cmd;
  logic can_push;
  logic acc;
  logic tick_go;
  logic add_done;

  assign cmd      = cmd_t'(in_command);
  assign can_push = ~out_valid_r | out_ready;
  assign in_ready = (state_r == ST_IDLE) & can_push;
  assign acc      = in_valid & in_ready;

  // Tick step allowed unless a report must wait for the output register
  always_comb begin
    tick_go = 1'b1;
    if (stat.hit && pend_valid_r && (nrep_r < NREP_W'(MAX_RESULTS)) && !can_push) begin
      tick_go = 1'b0;
    end
  end

  assign add_done = can_push & (stat.free | tok_last);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && cmd == CMD_ADD)  state_nxt = ST_ADD;
        if (acc && cmd == CMD_TICK) state_nxt = ST_TICK;
      end
      ST_ADD: begin
        if (add_done) state_nxt = ST_IDLE;
      end
      ST_TICK: begin
        if (tick_go && tok_last) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (can_push) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: cell control, result register and pending fire
  always_comb begin
    ctl                = '0;
    ctl.op             = OP_NONE;
    ctl.job_id         = in_job_id;
    ctl.repeat_limit   = lim_r;
    ctl.interval       = (state_r == ST_IDLE) ? in_interval_ticks : ivl_r;
    ctl.start_now      = start_r;
    ctl.free_when_done = fwd_r;

    out_valid_nxt = out_valid_r & ~out_ready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_fc_nxt    = out_fc_r;
    out_run_nxt   = out_run_r;
    out_last_nxt  = out_last_r;

    pend_valid_nxt = pend_valid_r;
    pend_slot_nxt  = pend_slot_r;
    pend_fc_nxt    = pend_fc_r;
    pend_run_nxt   = pend_run_r;
    nrep_nxt       = nrep_r;

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          out_slot_nxt = in_job_id;
          out_fc_nxt   = '0;
          out_run_nxt  = 1'b0;
          out_last_nxt = 1'b1;
          out_kind_nxt = KIND_ACK;
          case (cmd)
            CMD_ADD: begin
              ctl.inject = 1'b1;
              ctl.step   = 1'b1;
            end
            CMD_TICK: begin
              ctl.inject     = 1'b1;
              ctl.step       = 1'b1;
              nrep_nxt       = '0;
              pend_valid_nxt = 1'b0;
            end
            CMD_START: begin
              ctl.op        = OP_START;
              out_valid_nxt = 1'b1;
            end
            CMD_STOP: begin
              ctl.op        = OP_STOP;
              out_valid_nxt = 1'b1;
            end
            CMD_REMOVE: begin
              ctl.op        = OP_REMOVE;
              out_valid_nxt = 1'b1;
            end
            CMD_SET_INTERVAL: begin
              ctl.op        = OP_SETIV;
              out_valid_nxt = 1'b1;
            end
            CMD_QUERY: begin
              out_kind_nxt  = KIND_STATUS;
              out_run_nxt   = stat.qrun;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_ADD: begin
        if (can_push && stat.free) begin
          ctl.op        = OP_ADD;
          ctl.tok_clr   = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ADDED;
          out_slot_nxt  = stat.slot;
          out_fc_nxt    = '0;
          out_run_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
        end else if (can_push && tok_last) begin
          ctl.tok_clr   = 1'b1;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FULL;
          out_slot_nxt  = '0;
          out_fc_nxt    = '0;
          out_run_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
        end else if (!stat.free) begin
          ctl.step = 1'b1;
        end
      end

      ST_TICK: begin
        if (tick_go) begin
          ctl.op   = OP_TICK;
          ctl.step = 1'b1;
          if (stat.hit && (nrep_r < NREP_W'(MAX_RESULTS))) begin
            // Older pending fire goes out, this one takes its place
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_FIRED;
              out_slot_nxt  = pend_slot_r;
              out_fc_nxt    = pend_fc_r;
              out_run_nxt   = pend_run_r;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_slot_nxt  = stat.slot;
            pend_fc_nxt    = stat.fire_count;
            pend_run_nxt   = stat.run_after;
            nrep_nxt       = nrep_r + NREP_W'(1);
          end
        end
      end

      ST_FLUSH: begin
        if (can_push) begin
          out_valid_nxt  = 1'b1;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          if (pend_valid_r) begin
            out_kind_nxt = KIND_FIRED;
            out_slot_nxt = pend_slot_r;
            out_fc_nxt   = pend_fc_r;
            out_run_nxt  = pend_run_r;
          end else begin
            out_kind_nxt = KIND_IDLE_TICK;
            out_slot_nxt = '0;
            out_fc_nxt   = '0;
            out_run_nxt  = 1'b0;
          end
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      nrep_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      nrep_r       <= nrep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_fc_r    <= out_fc_nxt;
    out_run_r   <= out_run_nxt;
    out_last_r  <= out_last_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_fc_r   <= pend_fc_nxt;
    pend_run_r  <= pend_run_nxt;
    if (acc) begin
      lim_r   <= in_repeat_limit;
      ivl_r   <= in_interval_ticks;
      start_r <= in_start_now;
      fwd_r   <= in_free_when_done;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_slot       = out_slot_r;
  assign out_fire_count = out_fc_r;
  assign out_running    = out_run_r;
  assign out_last       = out_last_r;

  // Only a fire result can be followed by another one from the same transaction
  a_nonlast_is_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_kind_r == KIND_FIRED))
    else $error("non-final result is not a fire");

  // Pending fire exists only during a tick
  a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == ST_TICK || state_r == ST_FLUSH))
    else $error("pending fire outside tick");

  // Report count never passes the result limit
  a_nrep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nrep_r <= NREP_W'(MAX_RESULTS))
    else $error("report count overflow");

endmodule

@@ sv/periodic_job_timer_table.sv @@
// Channel   Handshake                Payload
// -------   ----------------------   ------------------------------------------------
// input     in_valid / in_ready      in_command, in_job_id, in_repeat_limit,
//                                    in_interval_ticks, in_start_now, in_free_when_done
// result    out_valid / out_ready    out_kind, out_slot, out_fire_count, out_running,
//                                    out_last
//
// Start, stop, remove, set interval, query: one result each.
// Add: the scan token visits cells up to a free one or the last, NUM_SLOTS at most.
// Tick: the token walks the cell row one slot per cycle; one fire result is buffered.
// A stalled result channel holds the token at a free cell or at a fire that must wait.
// rst_n (synchronous) clears in-use and active bits and the controller; no clearing pass.
module periodic_job_timer_table #(
  parameter int NUM_SLOTS = pjt_pkg::NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pjt_pkg::CMD_W-1:0]     in_command,
  input  logic [pjt_pkg::SLOT_W-1:0]    in_job_id,
  input  logic [pjt_pkg::LIMIT_W-1:0]   in_repeat_limit,
  input  logic [pjt_pkg::IVL_W-1:0]     in_interval_ticks,
  input  logic                          in_start_now,
  input  logic                          in_free_when_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pjt_pkg::KIND_W-1:0]    out_kind,
  output logic [pjt_pkg::SLOT_W-1:0]    out_slot,
  output logic [pjt_pkg::LIMIT_W-1:0]   out_fire_count,
  output logic                          out_running,
  output logic                          out_last
);
  import pjt_pkg::*;

  cell_ctl_t              ctl;
  cell_stat_t             cs [NUM_SLOTS];
  cell_stat_t             stat;
  logic [NUM_SLOTS-1:0]   tok_in;
  logic [NUM_SLOTS-1:0]   tok_out;

  // Row of slot cells, token chained from each to its neighbor
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    if (i == 0) begin : g_head
      assign tok_in[i] = ctl.inject;
    end else begin : g_link
      assign tok_in[i] = tok_out[i-1];
    end

    pjt_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .tok_in  (tok_in[i]),
      .tok_out (tok_out[i]),
      .stat    (cs[i])
    );
  end

  // Combine cell status; only the token holder or addressed cell drives ones
  always_comb begin
    stat = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      stat = stat | cs[i];
    end
  end

  pjt_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_job_id         (in_job_id),
    .in_repeat_limit   (in_repeat_limit),
    .in_interval_ticks (in_interval_ticks),
    .in_start_now      (in_start_now),
    .in_free_when_done (in_free_when_done),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_slot          (out_slot),
    .out_fire_count    (out_fire_count),
    .out_running       (out_running),
    .out_last          (out_last),
    .stat              (stat),
    .tok_last          (tok_out[NUM_SLOTS-1]),
    .ctl               (ctl)
  );

  // At most one cell holds the scan token
  a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_out))
    else $error("more than one scan token");

endmodule
